// ===== hdl/crng_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_pkg
// Shared constants, command/status types and derived widths for the
// combined congruential generator with shuffle table.
// ---------------------------------------------------------------------------
package crng_pkg;

   // Shuffle table geometry
   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int WARM_STEPS = TABLE_SIZE + 8;
   localparam int STEP_W     = $clog2(WARM_STEPS);

   // Field and datapath widths
   localparam int SEED_W  = 32;
   localparam int VALUE_W = 31;
   localparam int MUL_W   = 16;
   localparam int FOLD_W  = 8;
   localparam int PROD_W  = VALUE_W + MUL_W;

   // Generator constants (moduli sit just below 2^31, so 2^31 folds to a small value)
   localparam logic [VALUE_W-1:0] MOD_ONE  = 31'd2147483563;
   localparam logic [VALUE_W-1:0] MOD_TWO  = 31'd2147483399;
   localparam logic [MUL_W-1:0]   MUL_ONE  = 16'd40014;
   localparam logic [MUL_W-1:0]   MUL_TWO  = 16'd40692;
   localparam logic [FOLD_W-1:0]  FOLD_ONE = FOLD_W'(32'h8000_0000 - {1'b0, MOD_ONE});
   localparam logic [FOLD_W-1:0]  FOLD_TWO = FOLD_W'(32'h8000_0000 - {1'b0, MOD_TWO});
   localparam logic [VALUE_W-1:0] WRAP_ONE = MOD_ONE - 31'd1;

   // Table index from the previous output: value / BUCKET by reciprocal
   localparam longint BUCKET      = 1 + longint'(WRAP_ONE) / TABLE_SIZE;
   localparam int     BUCKET_W    = $clog2(BUCKET + 1);
   localparam int     RECIP_SHIFT = 37;
   localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / BUCKET + 1;
   localparam int     RECIP_W     = $clog2(RECIP + 1);
   localparam int     PICK_PW     = VALUE_W + RECIP_W;
   localparam int     QUO_W       = IDX_W + 1;
   localparam int     QB_W        = QUO_W + BUCKET_W;

   // Reset values of the generator state
   localparam logic signed [SEED_W-1:0] GEN_ONE_RESET = -32'sd849345;
   localparam logic [VALUE_W-1:0]       GEN_TWO_RESET = 31'd123456789;
   localparam logic [VALUE_W-1:0]       SHUFFLE_RESET = '0;

   // Input item kinds (carried on req_tuser)
   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_SEED = 1'b1
   } command_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load_seed;
      logic             reinit;
      logic             mul_issue;
      logic             mul_gen_two;
      logic             wb_one;
      logic             wb_two;
      logic             fill_wr;
      logic             fill_last;
      logic [IDX_W-1:0] fill_idx;
      logic             tbl_rd;
      logic             finish;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic gen_one_nonpos;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hdl/crng_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module crng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hdl/crng_modmul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_modmul
// Shared modular multiplier: a*z mod m for either generator, product registered.
// ---------------------------------------------------------------------------
module crng_modmul (
   input  wire logic                           clock,
   input  wire logic                           issue,
   input  wire logic                           sel_two,
   input  wire logic [crng_pkg::VALUE_W-1:0]   z,
   output logic      [crng_pkg::VALUE_W-1:0]   result
);

   localparam int HF_W = crng_pkg::MUL_W + crng_pkg::FOLD_W;

   logic [crng_pkg::MUL_W-1:0]   mul_k;
   logic [crng_pkg::PROD_W-1:0]  prod_in;
   logic [crng_pkg::PROD_W-1:0]  prod_ff;
   logic                         sel_two_ff;
   logic [crng_pkg::MUL_W-1:0]   hi;
   logic [crng_pkg::VALUE_W-1:0] lo;
   logic [crng_pkg::FOLD_W-1:0]  fold_k;
   logic [HF_W-1:0]              hi_fold;
   logic [crng_pkg::VALUE_W:0]   fold_sum;
   logic [crng_pkg::VALUE_W:0]   mod_ext;

   assign mul_k   = sel_two ? crng_pkg::MUL_TWO : crng_pkg::MUL_ONE;
   assign prod_in = crng_pkg::PROD_W'(z) * crng_pkg::PROD_W'(mul_k);

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff    <= prod_in;
         sel_two_ff <= sel_two;
      end
   end

   // Fold the high part back in (2^31 == small constant mod m), then one subtract
   always_comb begin
      hi       = prod_ff[crng_pkg::PROD_W-1:crng_pkg::VALUE_W];
      lo       = prod_ff[crng_pkg::VALUE_W-1:0];
      fold_k   = sel_two_ff ? crng_pkg::FOLD_TWO : crng_pkg::FOLD_ONE;
      hi_fold  = HF_W'(hi) * HF_W'(fold_k);
      fold_sum = {1'b0, lo} + (crng_pkg::VALUE_W + 1)'(hi_fold);
      mod_ext  = {1'b0, (sel_two_ff ? crng_pkg::MOD_TWO : crng_pkg::MOD_ONE)};
      if (fold_sum >= mod_ext) begin
         result = crng_pkg::VALUE_W'(fold_sum - mod_ext);
      end else begin
         result = fold_sum[crng_pkg::VALUE_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/crng_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_datapath
// Generator state, shared modular multiplier, shuffle table and the
// table index pipeline.
// ---------------------------------------------------------------------------
module crng_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire crng_pkg::dp_cmd_type                cmd,
   input  wire logic signed [crng_pkg::SEED_W-1:0]  seed,
   output crng_pkg::dp_status_type                  status,
   output logic [crng_pkg::VALUE_W-1:0]             rsp_data
);

   localparam int DIFF_W = crng_pkg::VALUE_W + 2;

   logic signed [crng_pkg::SEED_W-1:0] gen_one_ff, gen_one_in;
   logic [crng_pkg::VALUE_W-1:0]       gen_two_ff, gen_two_in;
   logic [crng_pkg::VALUE_W-1:0]       shuffle_out_ff, shuffle_out_in;
   logic [crng_pkg::VALUE_W-1:0]       rsp_data_ff;
   logic [crng_pkg::QUO_W-1:0]         q_est_ff, q_est_in;
   logic [crng_pkg::VALUE_W-1:0]       so_dly_ff;
   logic [crng_pkg::IDX_W-1:0]         pick_ff, pick_in;

   logic [crng_pkg::VALUE_W-1:0]       reinit_val;
   logic [crng_pkg::VALUE_W-1:0]       mul_z;
   logic [crng_pkg::VALUE_W-1:0]       mul_res;
   logic [crng_pkg::VALUE_W-1:0]       ram_rdata;
   logic [crng_pkg::VALUE_W-1:0]       ram_wdata;
   logic [crng_pkg::IDX_W-1:0]         ram_addr;
   logic                               ram_we;
   logic [DIFF_W-1:0]                  diff;
   logic [DIFF_W-1:0]                  diff_wrap;
   logic [crng_pkg::VALUE_W-1:0]       shuffle_new;
   logic [crng_pkg::PICK_PW-1:0]       pick_prod;
   logic [crng_pkg::QB_W-1:0]          back_prod;
   logic [crng_pkg::QUO_W-1:0]         q_corr;

   // Negate for re-initialization: zero becomes one, most negative saturates
   always_comb begin
      if (gen_one_ff == '0) begin
         reinit_val = crng_pkg::VALUE_W'(1);
      end else if (gen_one_ff == {1'b1, {(crng_pkg::SEED_W-1){1'b0}}}) begin
         reinit_val = '1;
      end else begin
         reinit_val = crng_pkg::VALUE_W'(-gen_one_ff);
      end
   end

   assign status.gen_one_nonpos = gen_one_ff[crng_pkg::SEED_W-1] | (gen_one_ff == '0);

   assign mul_z = cmd.mul_gen_two ? gen_two_ff : gen_one_ff[crng_pkg::VALUE_W-1:0];

   crng_modmul u_modmul (
      .clock   (clock),
      .issue   (cmd.mul_issue),
      .sel_two (cmd.mul_gen_two),
      .z       (mul_z),
      .result  (mul_res)
   );

   // Shuffle table: fill during warm-up, read-then-replace on a draw
   assign ram_we    = cmd.fill_wr | cmd.finish;
   assign ram_addr  = cmd.fill_wr ? cmd.fill_idx : pick_ff;
   assign ram_wdata = cmd.fill_wr ? mul_res : gen_one_ff[crng_pkg::VALUE_W-1:0];

   crng_ram #(
      .WIDTH (crng_pkg::VALUE_W),
      .DEPTH (crng_pkg::TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .re    (cmd.tbl_rd),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // New output: entry minus second generator, wrapped into range
   always_comb begin
      diff      = {2'b00, ram_rdata} - {2'b00, gen_two_ff};
      diff_wrap = diff + {2'b00, crng_pkg::WRAP_ONE};
      if ($signed(diff) < $signed(DIFF_W'(1))) begin
         shuffle_new = diff_wrap[crng_pkg::VALUE_W-1:0];
      end else begin
         shuffle_new = diff[crng_pkg::VALUE_W-1:0];
      end
   end

   // Index pipeline: reciprocal estimate, then one correction and a clamp
   always_comb begin
      pick_prod = crng_pkg::PICK_PW'(shuffle_out_ff) * crng_pkg::PICK_PW'(crng_pkg::RECIP);
      q_est_in  = crng_pkg::QUO_W'(pick_prod >> crng_pkg::RECIP_SHIFT);
      back_prod = crng_pkg::QB_W'(q_est_ff) * crng_pkg::QB_W'(crng_pkg::BUCKET);
      if (back_prod > crng_pkg::QB_W'(so_dly_ff)) begin
         q_corr = q_est_ff - crng_pkg::QUO_W'(1);
      end else begin
         q_corr = q_est_ff;
      end
      if (q_corr > crng_pkg::QUO_W'(crng_pkg::TABLE_SIZE - 1)) begin
         pick_in = crng_pkg::IDX_W'(crng_pkg::TABLE_SIZE - 1);
      end else begin
         pick_in = q_corr[crng_pkg::IDX_W-1:0];
      end
   end

   // Next state of the generators
   always_comb begin
      gen_one_in     = gen_one_ff;
      gen_two_in     = gen_two_ff;
      shuffle_out_in = shuffle_out_ff;
      if (cmd.load_seed) begin
         gen_one_in = seed;
      end else if (cmd.reinit) begin
         gen_one_in = {1'b0, reinit_val};
      end else if (cmd.wb_one) begin
         gen_one_in = {1'b0, mul_res};
      end
      if (cmd.reinit) begin
         gen_two_in = reinit_val;
      end else if (cmd.wb_two) begin
         gen_two_in = mul_res;
      end
      if (cmd.fill_last) begin
         shuffle_out_in = mul_res;
      end else if (cmd.finish) begin
         shuffle_out_in = shuffle_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_one_ff     <= crng_pkg::GEN_ONE_RESET;
         gen_two_ff     <= crng_pkg::GEN_TWO_RESET;
         shuffle_out_ff <= crng_pkg::SHUFFLE_RESET;
      end else begin
         gen_one_ff     <= gen_one_in;
         gen_two_ff     <= gen_two_in;
         shuffle_out_ff <= shuffle_out_in;
      end
   end

   always_ff @(posedge clock) begin
      q_est_ff  <= q_est_in;
      so_dly_ff <= shuffle_out_ff;
      pick_ff   <= pick_in;
      if (cmd.finish) begin
         rsp_data_ff <= shuffle_new;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/crng_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_ctrl
// Sequencer for seed loads, warm-up fill and draws; owns the output valid.
// ---------------------------------------------------------------------------
module crng_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_command,
   input  wire logic                    rsp_tready,
   input  wire crng_pkg::dp_status_type status,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   output crng_pkg::dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG,
      ST_WARM_ISSUE,
      ST_WARM_WB,
      ST_DRAW_ONE,
      ST_DRAW_TWO,
      ST_DRAW_WB,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [crng_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_command == crng_pkg::CMD_SEED) begin
                  cmd.load_seed = 1'b1;
               end else if (status.gen_one_nonpos) begin
                  state_in = ST_NEG;
               end else begin
                  state_in = ST_DRAW_ONE;
               end
            end
         end
         ST_NEG: begin
            cmd.reinit = 1'b1;
            step_in    = crng_pkg::STEP_W'(crng_pkg::WARM_STEPS - 1);
            state_in   = ST_WARM_ISSUE;
         end
         ST_WARM_ISSUE: begin
            cmd.mul_issue = 1'b1;
            state_in      = ST_WARM_WB;
         end
         ST_WARM_WB: begin
            cmd.wb_one = 1'b1;
            // the last TABLE_SIZE steps fill the table from the top down
            if (step_ff < crng_pkg::STEP_W'(crng_pkg::TABLE_SIZE)) begin
               cmd.fill_wr  = 1'b1;
               cmd.fill_idx = step_ff[crng_pkg::IDX_W-1:0];
            end
            if (step_ff == '0) begin
               cmd.fill_last = 1'b1;
               state_in      = ST_DRAW_ONE;
            end else begin
               step_in  = step_ff - crng_pkg::STEP_W'(1);
               state_in = ST_WARM_ISSUE;
            end
         end
         ST_DRAW_ONE: begin
            cmd.mul_issue = 1'b1;
            state_in      = ST_DRAW_TWO;
         end
         ST_DRAW_TWO: begin
            cmd.wb_one      = 1'b1;
            cmd.mul_issue   = 1'b1;
            cmd.mul_gen_two = 1'b1;
            state_in        = ST_DRAW_WB;
         end
         ST_DRAW_WB: begin
            cmd.wb_two = 1'b1;
            cmd.tbl_rd = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/combined_lcg_shuffle_rng_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-generator congruential random source with a shuffle table.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): each transfer is a seed load (req_tuser = 1,
//   req_tdata = new signed first-generator state) or a draw (req_tuser = 0,
//   req_tdata ignored). A seed load gives no result; a draw gives one.
//   Result channel (rsp_*): rsp_tdata[30:0] is the random integer in
//   1..2147483562; divide by 2147483563 for a uniform value in (0,1).
// Timing:
//   A seed load leaves the unit idle. A draw passes ST_DRAW_ONE, ST_DRAW_TWO,
//   ST_DRAW_WB and ST_FINISH, registering its result in ST_FINISH; the
//   two generator steps run back to back through one shared modular
//   multiplier with a registered product, then the table read-modify-write.
//   A draw that finds a non-positive first generator re-initializes first:
//   a NEG step, then TABLE_SIZE + 8 dependent multiplier steps, each an
//   issue and a write-back, filling the table on the way.
// Reset:
//   Synchronous, active high. The generators take their fixed start values,
//   so the first draw after reset re-initializes. The table is not cleared.
// Stalls:
//   The result sits in an output register; a new request is still accepted
//   while it waits, and a draw holds in its final step until it is taken.
// ---------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] seed (signed)
   input  wire logic        req_tuser,   // [0] command: 0 draw, 1 seed load
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [30:0] value, [31] zero
);

   crng_pkg::dp_cmd_type               cmd;
   crng_pkg::dp_status_type            status;
   logic [crng_pkg::VALUE_W-1:0]       rsp_data;
   logic signed [crng_pkg::SEED_W-1:0] seed;

   assign seed = $signed(req_tdata);

   // Sequencer: decides each cycle what the datapath does
   crng_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .cmd         (cmd)
   );

   // Datapath: generator state, multiplier, table and output register
   crng_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .seed     (seed),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // Pad the 31-bit value to a whole number of bytes
   assign rsp_tdata = {1'b0, rsp_data};

endmodule
`default_nettype wire

// ===== hdl/crng_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// crng_port_checks
// Port-level checks on transfer sequencing of the random unit.
// ---------------------------------------------------------------------------
module crng_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic seed_xfer;
   logic draw_xfer;

   assign seed_xfer = req_tvalid & req_tready & req_tuser;
   assign draw_xfer = req_tvalid & req_tready & ~req_tuser;

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A seed load leaves the request side open and produces no result
   assert property (@(posedge clock) disable iff (reset)
      seed_xfer |=> req_tready && !$rose(rsp_tvalid))
      else $error("seed load blocked the request side or produced a result");

   // A draw keeps the request side closed while it works
   assert property (@(posedge clock) disable iff (reset)
      draw_xfer |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request accepted during a draw");

   // A result only appears at the end of a draw
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while idle");

endmodule

bind combined_lcg_shuffle_rng_unit crng_port_checks u_checker (.*);
`default_nettype wire
